// ----- rtl/core/sha1_pkg.sv -----
// SHA-1 engine package: constants, shared types and round helper functions.
// No dependencies; used by the interfaces, the compression core and the top level.
package sha1_pkg;

	typedef logic [31:0] word_t;
	typedef logic [4:0][31:0] chain_t;
	typedef logic [6:0] round_t;
	typedef logic [3:0] pos_t;
	typedef logic [2:0] bcnt_t;

	localparam int unsigned NUM_DIGEST = 5;
	localparam round_t LAST_ROUND = 7'd79;

	// Initial chaining words, index 0 in the low slot
	localparam chain_t CHAIN_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
		32'hEFCDAB89, 32'h67452301};

	localparam word_t K_0 = 32'h5A827999;
	localparam word_t K_1 = 32'h6ED9EBA1;
	localparam word_t K_2 = 32'h8F1BBCDC;
	localparam word_t K_3 = 32'hCA62C1D6;

	localparam word_t PAD_MARK = 32'h8000_0000;
	localparam bcnt_t BYTES_FULL = 3'd4;
	localparam pos_t LEN_HI_POS = 4'd14;
	localparam pos_t LEN_LO_POS = 4'd15;
	localparam pos_t BLOCK_END = 4'd15;
	localparam logic [2:0] LAST_INDEX = 3'd4;

	// Control from the sequencer to the compression core
	typedef struct packed {
		logic load;
		word_t load_word;
		logic start;
		logic clear;
	} cmp_ctrl_t;

	function automatic word_t round_f(round_t r, word_t b, word_t c, word_t d);
		word_t f;
		if (r < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (r < 7'd40) begin
			f = b ^ c ^ d;
		end else if (r < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		return f;
	endfunction

	function automatic word_t round_k(round_t r);
		word_t k;
		if (r < 7'd20) begin
			k = K_0;
		end else if (r < 7'd40) begin
			k = K_1;
		end else if (r < 7'd60) begin
			k = K_2;
		end else begin
			k = K_3;
		end
		return k;
	endfunction

	// Final partial word: keep the valid bytes, place the 0x80 marker after them
	function automatic word_t tail_word(word_t w, bcnt_t n);
		word_t t;
		case (n)
			3'd0: t = PAD_MARK;
			3'd1: t = {w[31:24], 24'h80_0000};
			3'd2: t = {w[31:16], 16'h8000};
			3'd3: t = {w[31:8], 8'h80};
			default: t = w;
		endcase
		return t;
	endfunction

endpackage

// ----- rtl/core/sha1_if.sv -----
// Valid/ready channel interfaces for message input and digest output.
// Depends on sha1_pkg for the word type.
interface sha1_msg_if;
	logic valid;
	logic ready;
	sha1_pkg::word_t data_word;
	logic [2:0] byte_count;
	logic last;

	modport source (output valid, data_word, byte_count, last, input ready);
	modport sink (input valid, data_word, byte_count, last, output ready);
endinterface

interface sha1_dig_if;
	logic valid;
	logic ready;
	sha1_pkg::word_t digest_word;
	logic [2:0] word_index;
	logic last_word;

	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- rtl/core/sha1_digest_engine_unit.sv -----
// SHA-1 digest engine top level: input sequencer, padding, length and digest output.
// Depends on sha1_pkg, sha1_msg_if, sha1_dig_if and sha1_compress.
//
// Usage: message words arrive on msg (valid/ready), big-endian, four bytes each;
// the word with last set carries 0 to 4 bytes in its high bytes (byte_count).
// Each accepted word is shifted into the 16-word block window. The sixteenth
// word of a block starts a compression: 80 rounds at one per cycle in the
// shared round unit, then a feed-forward add, during which msg.ready is low.
// After the last word the padding, marker and 64-bit bit length are shifted in
// one word per cycle, pausing while a compression runs, and one or two more
// compressions run. The five digest words then appear on dig, index 0 first,
// with last_word on index 4; a stall on dig.ready simply holds the current word.
// Reset (arst_n low) or delivery of the fifth digest word returns the chaining
// words, bit length and word position to their initial values.
module sha1_digest_engine_unit (
	input logic      clk,
	input logic      arst_n,
	sha1_msg_if.sink msg,
	sha1_dig_if.source dig
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PAD  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0] state_q;
	sha1_pkg::pos_t pos_q;
	logic [63:0] len_q;
	logic mark_q, hi_done_q, pad_q, fin_q;
	logic [2:0] idx_q;

	logic msg_acc, dig_acc, put, wrap, cmp_done;
	sha1_pkg::bcnt_t cnt_c;
	sha1_pkg::word_t put_word;
	sha1_pkg::cmp_ctrl_t ctrl;
	sha1_pkg::chain_t chain;

	assign msg_acc = msg.valid && msg.ready;
	assign dig_acc = dig.valid && dig.ready;
	assign cnt_c = (msg.byte_count > sha1_pkg::BYTES_FULL) ? sha1_pkg::BYTES_FULL
		: msg.byte_count;

	// Word to shift into the block window this cycle
	always_comb begin
		put = 1'b0;
		put_word = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (msg_acc) begin
					put = 1'b1;
					if (!msg.last || cnt_c == sha1_pkg::BYTES_FULL) begin
						put_word = msg.data_word;
					end else begin
						put_word = sha1_pkg::tail_word(msg.data_word, cnt_c);
					end
				end
			end
			ST_PAD: begin
				put = 1'b1;
				if (mark_q) begin
					put_word = sha1_pkg::PAD_MARK;
				end else if (pos_q == sha1_pkg::LEN_HI_POS) begin
					put_word = len_q[63:32];
				end else if (pos_q == sha1_pkg::LEN_LO_POS && hi_done_q) begin
					put_word = len_q[31:0];
				end else begin
					put_word = '0;
				end
			end
			ST_WAIT, ST_OUT: put = 1'b0;
			default: put = 1'b0;
		endcase
	end

	assign wrap = put && (pos_q == sha1_pkg::BLOCK_END);

	always_comb begin
		ctrl.load = put;
		ctrl.load_word = put_word;
		ctrl.start = wrap;
		ctrl.clear = dig_acc && (idx_q == sha1_pkg::LAST_INDEX);
	end

	sha1_compress u_compress (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.done   (cmp_done),
		.chain  (chain)
	);

	// Message sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			len_q <= '0;
			mark_q <= 1'b0;
			hi_done_q <= 1'b0;
			pad_q <= 1'b0;
			fin_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (put) pos_q <= pos_q + 4'd1;
			unique case (state_q)
				ST_IDLE: begin
					if (msg_acc) begin
						if (msg.last) begin
							len_q <= len_q + {58'd0, cnt_c, 3'd0};
							pad_q <= 1'b1;
							mark_q <= (cnt_c == sha1_pkg::BYTES_FULL);
						end else begin
							len_q <= len_q + 64'd32;
						end
						if (wrap) state_q <= ST_WAIT;
						else if (msg.last) state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					if (mark_q) begin
						mark_q <= 1'b0;
					end else if (pos_q == sha1_pkg::LEN_HI_POS) begin
						hi_done_q <= 1'b1;
					end else if (pos_q == sha1_pkg::LEN_LO_POS && hi_done_q) begin
						fin_q <= 1'b1;
					end
					if (wrap) state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					idx_q <= '0;
					if (cmp_done) begin
						if (fin_q) state_q <= ST_OUT;
						else if (pad_q) state_q <= ST_PAD;
						else state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (dig_acc) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == sha1_pkg::LAST_INDEX) begin
							state_q <= ST_IDLE;
							len_q <= '0;
							pos_q <= '0;
							mark_q <= 1'b0;
							hi_done_q <= 1'b0;
							pad_q <= 1'b0;
							fin_q <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Channel outputs
	assign msg.ready = (state_q == ST_IDLE);
	assign dig.valid = (state_q == ST_OUT);
	assign dig.digest_word = chain[idx_q];
	assign dig.word_index = idx_q;
	assign dig.last_word = (idx_q == sha1_pkg::LAST_INDEX);

endmodule

// ----- rtl/core/sha1_compress.sv -----
// SHA-1 compression core: 16-word schedule window, working words and chaining words.
// One round per cycle over 80 rounds, then a feed-forward add. Depends on sha1_pkg.
module sha1_compress (
	input  logic               clk,
	input  logic               arst_n,
	input  sha1_pkg::cmp_ctrl_t ctrl,
	output logic               done,
	output sha1_pkg::chain_t   chain
);

	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_RND  = 2'd1;
	localparam logic [1:0] C_ADD  = 2'd2;

	logic [1:0] state_q;
	sha1_pkg::round_t round_q;
	sha1_pkg::chain_t chain_q;
	sha1_pkg::word_t window_q [16];
	sha1_pkg::word_t a_q, b_q, c_q, d_q, e_q;
	sha1_pkg::word_t sched_x, sched_next, temp;

	// Message schedule and round sum
	always_comb begin
		sched_x = window_q[13] ^ window_q[8] ^ window_q[2] ^ window_q[0];
		sched_next = {sched_x[30:0], sched_x[31]};
		temp = {a_q[26:0], a_q[31:27]} + sha1_pkg::round_f(round_q, b_q, c_q, d_q)
			+ e_q + sha1_pkg::round_k(round_q) + window_q[0];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			round_q <= '0;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					round_q <= '0;
					if (ctrl.start) state_q <= C_RND;
				end
				C_RND: begin
					round_q <= round_q + 7'd1;
					if (round_q == sha1_pkg::LAST_ROUND) state_q <= C_ADD;
				end
				C_ADD: state_q <= C_IDLE;
				default: state_q <= C_IDLE;
			endcase
		end
	end

	// Schedule window shifts on a load and on every round
	always_ff @(posedge clk) begin
		if (ctrl.load || state_q == C_RND) begin
			for (int i = 0; i < 15; i++) window_q[i] <= window_q[i + 1];
			window_q[15] <= ctrl.load ? ctrl.load_word : sched_next;
		end
		if (ctrl.start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
		end else if (state_q == C_RND) begin
			e_q <= d_q;
			d_q <= c_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			b_q <= a_q;
			a_q <= temp;
		end
	end

	// Chaining words: feed-forward add, cleared after each message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q <= sha1_pkg::CHAIN_INIT;
		end else if (ctrl.clear) begin
			chain_q <= sha1_pkg::CHAIN_INIT;
		end else if (state_q == C_ADD) begin
			chain_q[0] <= chain_q[0] + a_q;
			chain_q[1] <= chain_q[1] + b_q;
			chain_q[2] <= chain_q[2] + c_q;
			chain_q[3] <= chain_q[3] + d_q;
			chain_q[4] <= chain_q[4] + e_q;
		end
	end

	assign done = (state_q == C_ADD);
	assign chain = chain_q;

endmodule

// ----- tb/tb_sha1_digest_engine_unit.sv -----
// Self-checking testbench for sha1_digest_engine_unit: hashes directed and random
// messages and compares every digest word against a SHA-1 predictor kept in the bench.
// Depends on sha1_pkg, sha1_msg_if, sha1_dig_if and the engine RTL.
module tb_sha1_digest_engine_unit;

	localparam int unsigned IDLE_PCT = 72;
	localparam int unsigned BOTH_PCT = 16;
	localparam int unsigned MODE_SPAN = 24;     // words per traffic mode
	localparam int unsigned HOLD_CYCLES = 2500; // long output back-pressure
	localparam int unsigned DRAIN_CYCLES = 250;
	localparam int unsigned RAND_WORDS = 120;

	typedef enum logic [1:0] {
		TRAFFIC_FREE,
		TRAFFIC_SEND_IDLE,
		TRAFFIC_RECV_STALL,
		TRAFFIC_BOTH
	} traffic_t;

	typedef enum logic [1:0] {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES
	} fill_t;

	typedef struct {
		sha1_pkg::word_t data_word;
		sha1_pkg::bcnt_t byte_count;
		logic last;
	} msg_word_t;

	typedef struct {
		sha1_pkg::word_t digest_word;
		logic [2:0] word_index;
		logic last_word;
	} digest_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Locally held drive values, so every input is known from time zero
	logic snd_valid = 1'b0;
	sha1_pkg::word_t snd_data = '0;
	sha1_pkg::bcnt_t snd_count = '0;
	logic snd_last = 1'b0;
	logic rcv_ready = 1'b0;

	msg_word_t msg_q[$];
	digest_word_t digest_q[$];
	int unsigned words_in = 0;
	int unsigned hold_at = 32'hFFFF_FFFF;
	int unsigned hold_left = 0;
	logic hold_done = 1'b0;
	int unsigned errors = 0;

	// Predicted engine state
	sha1_pkg::word_t chain_st [5];
	sha1_pkg::word_t block_st [16];
	logic [63:0] msg_bits;
	logic [3:0] block_pos;

	sha1_msg_if msg_ch ();
	sha1_dig_if dig_ch ();

	assign msg_ch.valid = snd_valid;
	assign msg_ch.data_word = snd_data;
	assign msg_ch.byte_count = snd_count;
	assign msg_ch.last = snd_last;
	assign dig_ch.ready = rcv_ready;

	sha1_digest_engine_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.dig    (dig_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic sha1_pkg::word_t rotl(sha1_pkg::word_t v, int unsigned s);
		return (v << s) | (v >> (32 - s));
	endfunction

	task automatic sha1_init_state();
		chain_st[0] = 32'h67452301;
		chain_st[1] = 32'hEFCDAB89;
		chain_st[2] = 32'h98BADCFE;
		chain_st[3] = 32'h10325476;
		chain_st[4] = 32'hC3D2E1F0;
		msg_bits = '0;
		block_pos = '0;
	endtask

	task automatic sha1_compress();
		sha1_pkg::word_t w [80];
		sha1_pkg::word_t a, b, c, d, e, f, k, t;
		for (int r = 0; r < 16; r++) w[r] = block_st[r];
		for (int r = 16; r < 80; r++) w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
		a = chain_st[0];
		b = chain_st[1];
		c = chain_st[2];
		d = chain_st[3];
		e = chain_st[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = 32'h5A827999;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = 32'h6ED9EBA1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d;
				k = 32'hCA62C1D6;
			end
			t = rotl(a, 5) + f + e + k + w[r];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		chain_st[0] += a;
		chain_st[1] += b;
		chain_st[2] += c;
		chain_st[3] += d;
		chain_st[4] += e;
	endtask

	task automatic sha1_push(sha1_pkg::word_t w);
		block_st[block_pos] = w;
		block_pos = block_pos + 4'd1;
		if (block_pos == 4'd0) sha1_compress();
	endtask

	// Absorb one accepted word; the final word pads, closes and queues the digest
	task automatic sha1_take_word(sha1_pkg::word_t data, sha1_pkg::bcnt_t count, logic fin);
		sha1_pkg::bcnt_t n;
		sha1_pkg::word_t keep;
		digest_word_t dw;
		if (!fin) begin
			msg_bits += 64'd32;
			sha1_push(data);
			return;
		end
		n = (count > 3'd4) ? 3'd4 : count;
		msg_bits += 64'(n) * 64'd8;
		if (n == 3'd4) begin
			sha1_push(data);
			sha1_push(32'h8000_0000);
		end else begin
			keep = (n == 3'd0) ? 32'h0 : ~(32'hFFFF_FFFF >> (8 * n));
			sha1_push((data & keep) | (32'h8000_0000 >> (8 * n)));
		end
		// no room left for the length in this block
		if (block_pos > 4'd14) begin
			while (block_pos != 4'd0) sha1_push(32'h0);
		end
		while (block_pos < 4'd14) sha1_push(32'h0);
		sha1_push(msg_bits[63:32]);
		sha1_push(msg_bits[31:0]);
		for (int i = 0; i < sha1_pkg::NUM_DIGEST; i++) begin
			dw.digest_word = chain_st[i];
			dw.word_index = 3'(i);
			dw.last_word = (i == 4);
			digest_q.push_back(dw);
		end
		sha1_init_state();
	endtask

	// ---------------------------------------------------------------- stimulus

	function automatic traffic_t traffic_mode();
		return traffic_t'((words_in / MODE_SPAN) % 4);
	endfunction

	function automatic sha1_pkg::word_t fill_word(fill_t fill);
		sha1_pkg::word_t w;
		case (fill)
			FILL_ZERO: w = 32'h0;
			FILL_ONES: w = 32'hFFFF_FFFF;
			default: w = $urandom();
		endcase
		return w;
	endfunction

	// Queue a message of full words plus one final word; returns its word count
	function automatic int unsigned queue_msg(int unsigned full_words,
		sha1_pkg::bcnt_t tail_bytes, fill_t fill);
		msg_word_t mw;
		for (int unsigned i = 0; i < full_words; i++) begin
			mw.data_word = fill_word(fill);
			mw.byte_count = sha1_pkg::bcnt_t'($urandom_range(7)); // ignored on non-final
			mw.last = 1'b0;
			msg_q.push_back(mw);
		end
		mw.data_word = fill_word(fill);
		mw.byte_count = tail_bytes;
		mw.last = 1'b1;
		msg_q.push_back(mw);
		return full_words + 1;
	endfunction

	// ---------------------------------------------------------------- driver

	always @(posedge clk or negedge arst_n) begin : drv
		int unsigned idle_pct;
		msg_word_t mw;
		if (!arst_n) begin
			snd_valid <= 1'b0;
		end else begin
			if (snd_valid && msg_ch.ready) begin
				sha1_take_word(snd_data, snd_count, snd_last);
				words_in <= words_in + 1;
			end
			if (!snd_valid || msg_ch.ready) begin
				case (traffic_mode())
					TRAFFIC_SEND_IDLE: idle_pct = IDLE_PCT;
					TRAFFIC_BOTH: idle_pct = BOTH_PCT;
					default: idle_pct = 0;
				endcase
				if (msg_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					mw = msg_q.pop_front();
					snd_valid <= 1'b1;
					snd_data <= mw.data_word;
					snd_count <= mw.byte_count;
					snd_last <= mw.last;
				end else begin
					snd_valid <= 1'b0;
				end
			end
		end
	end

	// Long back-pressure once, at the start of the random messages
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (!hold_done && words_in >= hold_at) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin : rcv
		int unsigned stall_pct;
		if (!arst_n) begin
			rcv_ready <= 1'b0;
		end else begin
			case (traffic_mode())
				TRAFFIC_RECV_STALL: stall_pct = IDLE_PCT;
				TRAFFIC_BOTH: stall_pct = BOTH_PCT;
				default: stall_pct = 0;
			endcase
			rcv_ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin : mon
		digest_word_t want;
		if (arst_n && dig_ch.valid && rcv_ready) begin
			if (digest_q.size() == 0) begin
				$display("%0t unexpected digest word: expected none, actual %h index %0d",
					$time, dig_ch.digest_word, dig_ch.word_index);
				errors++;
			end else begin
				want = digest_q.pop_front();
				if (dig_ch.digest_word !== want.digest_word) begin
					$display("%0t digest_word mismatch: expected %h, actual %h",
						$time, want.digest_word, dig_ch.digest_word);
					errors++;
				end
				if (dig_ch.word_index !== want.word_index) begin
					$display("%0t word_index mismatch: expected %0d, actual %0d",
						$time, want.word_index, dig_ch.word_index);
					errors++;
				end
				if (dig_ch.last_word !== want.last_word) begin
					$display("%0t last_word mismatch: expected %b, actual %b",
						$time, want.last_word, dig_ch.last_word);
					errors++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin : seq
		int unsigned n_words;
		int unsigned full;
		sha1_init_state();

		// empty message, each tail size, oversized tail counts, zero and all-ones data
		n_words = queue_msg(0, 3'd0, FILL_RANDOM);
		n_words += queue_msg(0, 3'd1, FILL_ONES);
		n_words += queue_msg(0, 3'd2, FILL_RANDOM);
		n_words += queue_msg(0, 3'd3, FILL_ZERO);
		n_words += queue_msg(0, 3'd4, FILL_ONES);
		n_words += queue_msg(0, 3'd5, FILL_RANDOM);
		n_words += queue_msg(0, 3'd6, FILL_ONES);
		n_words += queue_msg(0, 3'd7, FILL_RANDOM);
		// marker lands in slot 14: the length needs a second block
		n_words += queue_msg(14, 3'd2, FILL_RANDOM);
		hold_at = n_words;

		// random messages: mostly short, some spanning two or three blocks
		n_words = 0;
		while (n_words < RAND_WORDS) begin
			full = ($urandom_range(3) == 0) ? $urandom_range(47, 28) : $urandom_range(18);
			n_words += queue_msg(full, sha1_pkg::bcnt_t'($urandom_range(7)), FILL_RANDOM);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (msg_q.size() != 0 || snd_valid) @(posedge clk);
		while (digest_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("sha1_digest_engine_unit verification clean");
		end else begin
			$display("sha1_digest_engine_unit verification failed");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("sha1_digest_engine_unit verification failed");
		$finish;
	end

endmodule

// ----- sha1_digest_engine_unit.f -----
rtl/core/sha1_pkg.sv
rtl/core/sha1_if.sv
rtl/core/sha1_compress.sv
rtl/core/sha1_digest_engine_unit.sv
tb/tb_sha1_digest_engine_unit.sv
